>>> hdl/tmpu_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoidal motion profile package
// Sequencer states, register indexes and fixed-point constants shared by the
// motion profile unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmpu_pkg;

	// Fractional bits of the position and velocity formats.
	localparam int FRAC_W = 16;

	// Control tick rate in hertz.
	localparam logic [31:0] TICK_RATE_HZ = 32'd1000;

	// ceil(2^35 / 10): floor(x / 10) = (x * RECIP10) >> 35 for any 32-bit x.
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
	localparam int RECIP10_SHIFT = 35;

	// ceil(2^36 / 125): floor(x / 125) = (x * RECIP125) >> 36 for x below 2^29.
	localparam logic [31:0] RECIP125 = 32'd549_755_814;
	localparam int RECIP125_SHIFT = 36;

	// Result bits produced by the square-root iteration.
	localparam int ROOT_STEPS = 32;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MAX_VELOCITY     = 2'd0;
	localparam logic [1:0] CFG_MAX_ACCELERATION = 2'd1;
	localparam logic [1:0] CFG_MIN_POSITION     = 2'd2;
	localparam logic [1:0] CFG_MAX_POSITION     = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CONV,
		S_CLAMP,
		S_STEP,
		S_MLO,
		S_MHI,
		S_SUM,
		S_ROOT,
		S_VEL,
		S_DELTA,
		S_DIV,
		S_POS,
		S_AMUL,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

>>> hdl/trapezoidal_motion_profile_unit.sv
// ----------------------------------------------------------------------------
// Trapezoidal motion profile unit
// A control tick runs through conversion, clamping, the acceleration products,
// the bit-per-cycle square-root iteration and the velocity, position and
// acceleration updates; a restart goes from clamping to the acceleration product.
// Reset clears position, velocity and the result valid flag, and loads the default limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trapezoidal_motion_profile_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic [15:0]        goal_position_tenths,
	input  wire logic [15:0]        present_position_tenths,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [15:0]             set_position_tenths,
	output logic signed [16:0]      set_velocity_dps,
	output logic signed [16:0]      set_acceleration_dpss
);

	tmpu_pkg::state_t state_q, state_d;

	logic [15:0] max_vel_q;
	logic [15:0] max_acc_q;
	logic [11:0] min_pos_q;
	logic [11:0] max_pos_q;

	logic [39:0] pos_q;
	logic [32:0] vel_q;
	logic [23:0] dv_q;

	logic        cmd_q;
	logic [15:0] goal_q;
	logic [15:0] present_q;

	logic [63:0] prod_q;
	logic [40:0] dist_q;
	logic [39:0] mag_q;
	logic        dist_pos_q;
	logic [22:0] step_q;
	logic [47:0] lo_q;
	logic        big_q;
	logic [63:0] rad_q;
	logic [32:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic [33:0] diff_q;

	logic        out_valid_q;
	logic [15:0] out_pos_q;
	logic [16:0] out_vel_q;
	logic [16:0] out_acc_q;

	logic        mul_en;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic        out_load;

	logic [15:0] tenths_sel;
	logic [28:0] goal_f;
	logic [28:0] lo_lim;
	logic [28:0] hi_lim;
	logic [28:0] goal_cl;
	logic [40:0] dist_full;
	logic [40:0] dist_neg;
	logic [56:0] psum;
	logic [34:0] rem_sh;
	logic [34:0] trial;
	logic        root_ge;
	logic [34:0] rem_sub;
	logic [31:0] vlim;
	logic [31:0] vmag;
	logic [32:0] vmax;
	logic [33:0] step_ext;
	logic [23:0] delta;
	logic [32:0] vabs_full;
	logic [31:0] vabs;
	logic [22:0] div_q;
	logic [23:0] inc;
	logic [40:0] pos_sum;
	logic [39:0] pos_new;
	logic [23:0] dvabs_full;
	logic [43:0] p10;
	logic [27:0] p_tenths;
	logic [15:0] pos_out;
	logic [15:0] vel_whole;
	logic [17:0] acc_whole;
	logic [15:0] acc_sat;

	localparam logic [4:0]  ROOT_LAST = 5'(tmpu_pkg::ROOT_STEPS - 1);
	localparam logic [39:0] POS_MAX   = {1'b0, {39{1'b1}}};
	localparam logic [39:0] POS_MIN   = {1'b1, {39{1'b0}}};

	// Datapath arithmetic
	always_comb begin
		tenths_sel = cmd_q ? present_q : goal_q;
		goal_f     = prod_q[63:tmpu_pkg::RECIP10_SHIFT];
		lo_lim     = {1'b0, min_pos_q, {tmpu_pkg::FRAC_W{1'b0}}};
		hi_lim     = {1'b0, max_pos_q, {tmpu_pkg::FRAC_W{1'b0}}};
		if (goal_f < lo_lim) begin
			goal_cl = lo_lim;
		end else if (goal_f > hi_lim) begin
			goal_cl = hi_lim;
		end else begin
			goal_cl = goal_f;
		end
		dist_full = {12'd0, goal_cl} - {pos_q[39], pos_q};
		dist_neg  = 41'd0 - dist_q;

		psum = {prod_q[24:0], 32'd0} + {9'd0, lo_q};

		rem_sh  = {rem_q, rad_q[63:62]};
		trial   = {1'b0, root_q, 2'b01};
		root_ge = rem_sh >= trial;
		rem_sub = rem_sh - trial;

		vlim = {max_vel_q, {tmpu_pkg::FRAC_W{1'b0}}};
		vmag = (big_q || (root_q > vlim)) ? vlim : root_q;
		vmax = dist_pos_q ? {1'b0, vmag} : (33'd0 - {1'b0, vmag});

		step_ext = {11'd0, step_q};
		if ($signed(diff_q) > $signed(step_ext)) begin
			delta = {1'b0, step_q};
		end else if ($signed(diff_q) < -$signed(step_ext)) begin
			delta = 24'd0 - {1'b0, step_q};
		end else begin
			delta = diff_q[23:0];
		end

		vabs_full = vel_q[32] ? (33'd0 - vel_q) : vel_q;
		vabs      = vabs_full[31:0];
		div_q     = prod_q[58:tmpu_pkg::RECIP125_SHIFT];
		inc       = vel_q[32] ? (24'd0 - {1'b0, div_q}) : {1'b0, div_q};
		pos_sum   = {pos_q[39], pos_q} + {{17{inc[23]}}, inc};
		if (pos_sum[40] != pos_sum[39]) begin
			pos_new = pos_sum[40] ? POS_MIN : POS_MAX;
		end else begin
			pos_new = pos_sum[39:0];
		end

		dvabs_full = dv_q[23] ? (24'd0 - dv_q) : dv_q;

		p10      = {2'd0, pos_q[38:0], 3'd0} + {4'd0, pos_q[38:0], 1'b0};
		p_tenths = p10[43:16];
		if (pos_q[39] || (pos_q == 40'd0)) begin
			pos_out = 16'd0;
		end else if (|p_tenths[27:16]) begin
			pos_out = 16'hFFFF;
		end else begin
			pos_out = p_tenths[15:0];
		end
		vel_whole = vabs[31:16];
		acc_whole = prod_q[33:16];
		acc_sat   = (acc_whole[17] || acc_whole[16]) ? 16'hFFFF : acc_whole[15:0];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tmpu_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = tmpu_pkg::S_CONV;
				end
			end
			tmpu_pkg::S_CONV:  state_d = tmpu_pkg::S_CLAMP;
			tmpu_pkg::S_CLAMP: state_d = cmd_q ? tmpu_pkg::S_AMUL : tmpu_pkg::S_STEP;
			tmpu_pkg::S_STEP:  state_d = tmpu_pkg::S_MLO;
			tmpu_pkg::S_MLO:   state_d = tmpu_pkg::S_MHI;
			tmpu_pkg::S_MHI:   state_d = tmpu_pkg::S_SUM;
			tmpu_pkg::S_SUM:   state_d = tmpu_pkg::S_ROOT;
			tmpu_pkg::S_ROOT: begin
				if (cnt_q == ROOT_LAST) begin
					state_d = tmpu_pkg::S_VEL;
				end
			end
			tmpu_pkg::S_VEL:   state_d = tmpu_pkg::S_DELTA;
			tmpu_pkg::S_DELTA: state_d = tmpu_pkg::S_DIV;
			tmpu_pkg::S_DIV:   state_d = tmpu_pkg::S_POS;
			tmpu_pkg::S_POS:   state_d = tmpu_pkg::S_AMUL;
			tmpu_pkg::S_AMUL:  state_d = tmpu_pkg::S_DONE;
			tmpu_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = tmpu_pkg::S_IDLE;
				end
			end
			default: state_d = tmpu_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and shared multiplier operands
	always_comb begin
		in_stall = 1'b1;
		mul_en   = 1'b0;
		mul_a    = 32'd0;
		mul_b    = 32'd0;
		out_load = 1'b0;
		case (state_q)
			tmpu_pkg::S_IDLE: begin
				in_stall = 1'b0;
			end
			tmpu_pkg::S_CONV: begin
				mul_en = 1'b1;
				mul_a  = {tenths_sel, {tmpu_pkg::FRAC_W{1'b0}}};
				mul_b  = tmpu_pkg::RECIP10;
			end
			tmpu_pkg::S_CLAMP: begin
				mul_en = 1'b1;
				mul_a  = {3'd0, max_acc_q, 13'd0};
				mul_b  = tmpu_pkg::RECIP125;
			end
			tmpu_pkg::S_MLO: begin
				mul_en = 1'b1;
				mul_a  = mag_q[31:0];
				mul_b  = {16'd0, max_acc_q};
			end
			tmpu_pkg::S_MHI: begin
				mul_en = 1'b1;
				mul_a  = {24'd0, mag_q[39:32]};
				mul_b  = {16'd0, max_acc_q};
			end
			tmpu_pkg::S_DIV: begin
				mul_en = 1'b1;
				mul_a  = {3'd0, vabs[31:3]};
				mul_b  = tmpu_pkg::RECIP125;
			end
			tmpu_pkg::S_AMUL: begin
				mul_en = 1'b1;
				mul_a  = {9'd0, dvabs_full[22:0]};
				mul_b  = tmpu_pkg::TICK_RATE_HZ;
			end
			tmpu_pkg::S_DONE: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Control state, limits and profile state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tmpu_pkg::S_IDLE;
			max_vel_q   <= 16'd0;
			max_acc_q   <= 16'd0;
			min_pos_q   <= 12'd0;
			max_pos_q   <= 12'hFFF;
			pos_q       <= 40'd0;
			vel_q       <= 33'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					tmpu_pkg::CFG_MAX_VELOCITY:     max_vel_q <= cfg_data;
					tmpu_pkg::CFG_MAX_ACCELERATION: max_acc_q <= cfg_data;
					tmpu_pkg::CFG_MIN_POSITION:     min_pos_q <= cfg_data[11:0];
					tmpu_pkg::CFG_MAX_POSITION:     max_pos_q <= cfg_data[11:0];
					default: begin
					end
				endcase
			end
			case (state_q)
				tmpu_pkg::S_CLAMP: begin
					if (cmd_q) begin
						pos_q <= {11'd0, goal_f};
						vel_q <= 33'd0;
					end
				end
				tmpu_pkg::S_DELTA: vel_q <= vel_q + {{9{delta[23]}}, delta};
				tmpu_pkg::S_POS:   pos_q <= pos_new;
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the sequence
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (state_q)
			tmpu_pkg::S_IDLE: begin
				cmd_q     <= command;
				goal_q    <= goal_position_tenths;
				present_q <= present_position_tenths;
			end
			tmpu_pkg::S_CLAMP: begin
				dist_q <= dist_full;
				dv_q   <= 24'd0;
			end
			tmpu_pkg::S_STEP: begin
				step_q     <= prod_q[58:tmpu_pkg::RECIP125_SHIFT];
				mag_q      <= dist_q[40] ? dist_neg[39:0] : dist_q[39:0];
				dist_pos_q <= !dist_q[40] && (dist_q != 41'd0);
			end
			tmpu_pkg::S_MHI: begin
				lo_q <= prod_q[47:0];
			end
			tmpu_pkg::S_SUM: begin
				// The radicand is 2*a*|d| scaled by the fraction; a radicand of
				// 2^48 or more has a root above any speed limit.
				big_q  <= |psum[56:47];
				rad_q  <= {psum[46:0], 17'd0};
				rem_q  <= 33'd0;
				root_q <= 32'd0;
				cnt_q  <= 5'd0;
			end
			tmpu_pkg::S_ROOT: begin
				rem_q  <= root_ge ? rem_sub[32:0] : rem_sh[32:0];
				root_q <= {root_q[30:0], root_ge};
				rad_q  <= {rad_q[61:0], 2'b00};
				cnt_q  <= cnt_q + 5'd1;
			end
			tmpu_pkg::S_VEL: begin
				diff_q <= {vmax[32], vmax} - {vel_q[32], vel_q};
			end
			tmpu_pkg::S_DELTA: begin
				dv_q <= delta;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_pos_q <= pos_out;
			out_vel_q <= vel_q[32] ? (17'd0 - {1'b0, vel_whole}) : {1'b0, vel_whole};
			out_acc_q <= dv_q[23] ? (17'd0 - {1'b0, acc_sat}) : {1'b0, acc_sat};
		end
	end

	assign out_valid             = out_valid_q;
	assign set_position_tenths   = out_pos_q;
	assign set_velocity_dps      = out_vel_q;
	assign set_acceleration_dpss = out_acc_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == tmpu_pkg::S_CONV))
		else $error("accepted transaction did not start the sequence");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == tmpu_pkg::S_DONE))
		else $error("result presented outside the completion state");

	a_root_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tmpu_pkg::S_ROOT && cnt_q == ROOT_LAST) |=>
		(state_q == tmpu_pkg::S_VEL))
		else $error("square-root iteration ran the wrong number of steps");
`endif

endmodule

`default_nettype wire
